// ===== rtl/core/bve_pkg.sv =====
`default_nettype none

package bve_pkg;

    // Fixed field widths of the request and result ports
    localparam int REQ_W    = 3;
    localparam int IDX_W    = 11;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    // Widest element the store supports
    localparam int MAX_EW = 64;

    // Default sizing of the store
    localparam int CAPACITY_DEF      = 1024;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // Request codes; the two unused codes fall to a default arm
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_SET    = 3'd1,
        REQ_GET    = 3'd2,
        REQ_INSERT = 3'd3,
        REQ_DELETE = 3'd4,
        REQ_FIND   = 3'd5
    } t_req;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Strobes from the sequencer to the element store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/bve_mem.sv =====
`default_nettype none

module bve_mem #(
    parameter int DEPTH = bve_pkg::CAPACITY_DEF,
    parameter int WIDTH = bve_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire bve_pkg::t_mem_ctl        i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry and read one entry per cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/bve_seq.sv =====
`default_nettype none

module bve_seq #(
    parameter int CAPACITY      = bve_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = bve_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [bve_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [bve_pkg::IDX_W-1:0]       i_index,
    input  wire logic [bve_pkg::VAL_W-1:0]       i_value,
    output logic                                 o_done,
    output logic [bve_pkg::STATUS_W-1:0]         o_status,
    output logic [bve_pkg::VAL_W-1:0]            o_read_value,
    output logic [bve_pkg::IDX_W-1:0]            o_found_index,
    output logic                                 o_found,
    output logic [bve_pkg::IDX_W-1:0]            o_element_count,
    output bve_pkg::t_mem_ctl                    o_mem_ctl,
    output logic [$clog2(CAPACITY)-1:0]          o_raddr,
    output logic [$clog2(CAPACITY)-1:0]          o_waddr,
    output logic [ELEMENT_WIDTH-1:0]             o_wdata,
    input  wire logic [ELEMENT_WIDTH-1:0]        i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > bve_pkg::IDX_W) ? CW : bve_pkg::IDX_W;
    localparam int EW = ELEMENT_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FILL
    } t_state;

    t_state                        r_state, n_state;
    bve_pkg::t_req                 r_op, n_op;
    logic [AW-1:0]                 r_idx, n_idx;
    logic [EW-1:0]                 r_val, n_val;
    logic [CW-1:0]                 r_count, n_count;
    logic [AW-1:0]                 r_ptr, n_ptr;
    logic [AW-1:0]                 r_end, n_end;
    logic                          r_up, n_up;
    logic                          r_last, n_last;
    logic                          r_pend, n_pend;
    logic                          r_plast, n_plast;
    logic [AW-1:0]                 r_paddr, n_paddr;
    logic [EW-1:0]                 r_removed, n_removed;

    logic                          r_done, n_done;
    bve_pkg::t_status              r_status, n_status;
    logic [bve_pkg::VAL_W-1:0]     r_read, n_read;
    logic [bve_pkg::IDX_W-1:0]     r_fidx, n_fidx;
    logic                          r_found, n_found;
    logic [bve_pkg::IDX_W-1:0]     r_ecnt, n_ecnt;

    logic [bve_pkg::MAX_EW-1:0]    in_wide;
    logic [bve_pkg::MAX_EW-1:0]    rd_wide;
    logic [EW-1:0]                 in_val;
    logic [bve_pkg::VAL_W-1:0]     rd_val;
    logic [XW-1:0]                 x_idx;
    logic [XW-1:0]                 x_cnt;
    logic                          full;
    logic                          accept;
    bve_pkg::t_req                 req;

    // Widen a stored element to the result port width
    function automatic logic [bve_pkg::VAL_W-1:0] rd_wide_removed(input logic [EW-1:0] e);
        logic [bve_pkg::MAX_EW-1:0] w;
        w         = '0;
        w[EW-1:0] = e;
        return w[bve_pkg::VAL_W-1:0];
    endfunction

    // Fit the request value to the element width and the read data to the port
    always_comb begin
        in_wide          = bve_pkg::MAX_EW'(i_value);
        in_val           = in_wide[EW-1:0];
        rd_wide          = '0;
        rd_wide[EW-1:0]  = i_rdata;
        rd_val           = rd_wide[bve_pkg::VAL_W-1:0];
    end

    // Bounds and capacity checks on the incoming request
    assign x_idx  = XW'(i_index);
    assign x_cnt  = XW'(r_count);
    assign full   = (r_count == CW'(CAPACITY));
    assign accept = i_start && (r_state == S_IDLE);
    assign req    = bve_pkg::t_req'(i_req_type);

    // Sequencer: decode, walk the store one entry a cycle, respond
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_val     = r_val;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_end     = r_end;
        n_up      = r_up;
        n_last    = r_last;
        n_pend    = 1'b0;
        n_plast   = r_plast;
        n_paddr   = r_paddr;
        n_removed = r_removed;

        n_done    = 1'b0;
        n_status  = bve_pkg::ST_OK;
        n_read    = '0;
        n_fidx    = '0;
        n_found   = 1'b0;
        n_ecnt    = bve_pkg::IDX_W'(r_count);

        o_mem_ctl = '0;
        o_raddr   = r_ptr;
        o_waddr   = r_idx;
        o_wdata   = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = req;
                    n_idx  = AW'(i_index);
                    n_val  = in_val;
                    n_last = 1'b0;
                    unique case (req)
                        bve_pkg::REQ_APPEND: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = bve_pkg::ST_FULL;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_waddr         = AW'(r_count);
                                o_wdata         = in_val;
                                n_count         = CW'(r_count + 1'b1);
                                n_ecnt          = bve_pkg::IDX_W'(CW'(r_count + 1'b1));
                            end
                        end
                        bve_pkg::REQ_SET: begin
                            n_done = 1'b1;
                            if (x_idx >= x_cnt) begin
                                n_status = bve_pkg::ST_RANGE;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_waddr         = AW'(i_index);
                                o_wdata         = in_val;
                            end
                        end
                        bve_pkg::REQ_GET: begin
                            if (x_idx >= x_cnt) begin
                                n_done   = 1'b1;
                                n_status = bve_pkg::ST_RANGE;
                            end else begin
                                n_state = S_WALK;
                                n_ptr   = AW'(i_index);
                                n_end   = AW'(i_index);
                                n_up    = 1'b1;
                            end
                        end
                        bve_pkg::REQ_INSERT: begin
                            if (x_idx > x_cnt) begin
                                n_done   = 1'b1;
                                n_status = bve_pkg::ST_RANGE;
                            end else if (full) begin
                                n_done   = 1'b1;
                                n_status = bve_pkg::ST_FULL;
                            end else if (x_idx == x_cnt) begin
                                n_state = S_FILL;
                            end else begin
                                // shift from the top entry down to the index
                                n_state = S_WALK;
                                n_ptr   = AW'(CW'(r_count - 1'b1));
                                n_end   = AW'(i_index);
                                n_up    = 1'b0;
                            end
                        end
                        bve_pkg::REQ_DELETE: begin
                            if (x_idx >= x_cnt) begin
                                n_done   = 1'b1;
                                n_status = bve_pkg::ST_RANGE;
                            end else begin
                                n_state = S_WALK;
                                n_ptr   = AW'(i_index);
                                n_end   = AW'(CW'(r_count - 1'b1));
                                n_up    = 1'b1;
                            end
                        end
                        bve_pkg::REQ_FIND: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_WALK;
                                n_ptr   = '0;
                                n_end   = AW'(CW'(r_count - 1'b1));
                                n_up    = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // Issue the next read until the end address has gone out
                if (!r_last) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = r_ptr;
                    n_pend          = 1'b1;
                    n_paddr         = r_ptr;
                    n_last          = (r_ptr == r_end);
                    n_plast         = (r_ptr == r_end);
                    n_ptr           = r_up ? AW'(r_ptr + 1'b1) : AW'(r_ptr - 1'b1);
                end

                // Consume the entry read in the previous cycle
                if (r_pend) begin
                    unique case (r_op)
                        bve_pkg::REQ_GET: begin
                            n_done  = 1'b1;
                            n_read  = rd_val;
                            n_state = S_IDLE;
                        end
                        bve_pkg::REQ_INSERT: begin
                            o_mem_ctl.wr_en = 1'b1;
                            o_waddr         = AW'(r_paddr + 1'b1);
                            o_wdata         = i_rdata;
                            if (r_plast) begin
                                n_state = S_FILL;
                            end
                        end
                        bve_pkg::REQ_DELETE: begin
                            if (r_paddr == r_idx) begin
                                n_removed = i_rdata;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_waddr         = AW'(r_paddr - 1'b1);
                                o_wdata         = i_rdata;
                            end
                            if (r_plast) begin
                                n_done  = 1'b1;
                                n_read  = (r_paddr == r_idx) ? rd_val : rd_wide_removed(r_removed);
                                n_count = CW'(r_count - 1'b1);
                                n_ecnt  = bve_pkg::IDX_W'(CW'(r_count - 1'b1));
                                n_state = S_IDLE;
                            end
                        end
                        bve_pkg::REQ_FIND: begin
                            if (i_rdata == r_val) begin
                                n_done  = 1'b1;
                                n_found = 1'b1;
                                n_fidx  = bve_pkg::IDX_W'(r_paddr);
                                n_state = S_IDLE;
                            end else if (r_plast) begin
                                n_done  = 1'b1;
                                n_fidx  = bve_pkg::IDX_W'(r_count);
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_FILL: begin
                // Drop the new element into the freed slot
                o_mem_ctl.wr_en = 1'b1;
                o_waddr         = r_idx;
                o_wdata         = r_val;
                n_count         = CW'(r_count + 1'b1);
                n_ecnt          = bve_pkg::IDX_W'(CW'(r_count + 1'b1));
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_last  <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_ptr     <= n_ptr;
        r_end     <= n_end;
        r_up      <= n_up;
        r_plast   <= n_plast;
        r_paddr   <= n_paddr;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_read    <= n_read;
        r_fidx    <= n_fidx;
        r_found   <= n_found;
        r_ecnt    <= n_ecnt;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_value    = r_read;
    assign o_found_index   = r_fidx;
    assign o_found         = r_found;
    assign o_element_count = r_ecnt;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_vector_engine.sv =====
`default_nettype none

// Bounded vector engine: an ordered list of elements in a single-port-read,
// single-port-write store of CAPACITY entries, plus an element count.
// A request (i_req_type, i_index, i_value) is taken on a rising edge with
// start high and busy low. Each request gives exactly one result, shown for
// one cycle with o_done high; the receiver cannot hold it off.
// Append, set, failed checks and unused codes answer straight from idle,
// and busy stays low. Get walks the one entry at the index. Insert walks
// from the top entry down to the index, shifting each entry up, then writes
// the new element in a fill step; inserting at the end goes straight to the
// fill step. Delete walks from the index to the top entry, shifting each
// entry down. Find walks from the first entry up to the first match or the
// top entry, and answers straight from idle on an empty list.
// The walk reads one entry per cycle through the store's registered read
// port and, for insert and delete, writes the shifted entry back on the next.
// Busy drops in the cycle the result is shown, so the next request can be
// taken at the edge that ends it.
// Reset clears the count and the sequencer; the store itself is not cleared,
// as only positions below the count are ever read.

module bounded_vector_engine #(
    parameter int CAPACITY      = bve_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = bve_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bve_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [bve_pkg::IDX_W-1:0]     i_index,
    input  wire logic [bve_pkg::VAL_W-1:0]     i_value,
    output logic                               o_done,
    output logic [bve_pkg::STATUS_W-1:0]       o_status,
    output logic [bve_pkg::VAL_W-1:0]          o_read_value,
    output logic [bve_pkg::IDX_W-1:0]          o_found_index,
    output logic                               o_found,
    output logic [bve_pkg::IDX_W-1:0]          o_element_count
);

    localparam int AW = $clog2(CAPACITY);

    bve_pkg::t_mem_ctl        mem_ctl;
    logic [AW-1:0]            mem_raddr;
    logic [AW-1:0]            mem_waddr;
    logic [ELEMENT_WIDTH-1:0] mem_wdata;
    logic [ELEMENT_WIDTH-1:0] mem_rdata;

    // Sequencer with the address and compare path
    bve_seq #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_req_type      (i_req_type),
        .i_index         (i_index),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_value    (o_read_value),
        .o_found_index   (o_found_index),
        .o_found         (o_found),
        .o_element_count (o_element_count),
        .o_mem_ctl       (mem_ctl),
        .o_raddr         (mem_raddr),
        .o_waddr         (mem_waddr),
        .o_wdata         (mem_wdata),
        .i_rdata         (mem_rdata)
    );

    // Element store
    bve_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEMENT_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_raddr (mem_raddr),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
